// ----- hdl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescaper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package jsu_pkg;

  // Depth of the queue between the decoder and the serialiser.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Decoder phase within a literal.
  typedef enum logic [2:0] {
    PH_AWAIT = 3'd0,
    PH_TEXT  = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX   = 3'd3,
    PH_BSL   = 3'd4,
    PH_U     = 3'd5,
    PH_LOW   = 3'd6,
    PH_HUNT  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NO_QUOTE     = 4'd0,
    ERR_CONTROL      = 4'd1,
    ERR_OPEN_ESC     = 4'd2,
    ERR_SHORT_U      = 4'd3,
    ERR_BAD_HEX      = 4'd4,
    ERR_BAD_LOW_HEX  = 4'd5,
    ERR_BAD_LOW      = 4'd6,
    ERR_LONE_HIGH    = 4'd7,
    ERR_LONE_LOW     = 4'd8,
    ERR_BAD_ESCAPE   = 4'd9,
    ERR_UNTERMINATED = 4'd10
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] out_byte;
    err_t       error_code;
    logic       run_last;
  } out_word_t;

  // Everything one source byte produces: up to four data bytes, then an
  // optional completion or error.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      nbytes;
    logic            has_term;
    kind_t           term_kind;
    err_t            term_err;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- hdl/json_string_unescape.sv -----
// Top level of the JSON string unescaper: decoder, bundle queue, serialiser.
// Uses jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   Channel | Direction | Handshake         | Word
//   in_     | input     | in_valid/in_stall  | in_word_t  (in_byte, end_of_input)
//   out_    | output    | out_valid/out_stall| out_word_t (result_kind, out_byte,
//           |           |                    |   error_code, run_last)
//
// The decoder takes one source byte per cycle while the queue is not full and
// turns it, in that same cycle, into a bundle of zero to five results held in
// a four-entry queue. The serialiser moves one result per cycle from the queue
// head into the output register while it is empty or out_stall is low.
// in_stall rises only while the queue is full; each result passes through the
// queue and then the output register.
// Reset (synchronous, active low) empties the queue and the output register
// and leaves the decoder awaiting an opening quote.
`default_nettype none

module json_string_unescape import jsu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_word_t  in_data,
  output logic           in_stall,
  output logic           out_valid,
  output out_word_t      out_data,
  input  wire logic      out_stall
);

  logic    push, pop;
  bundle_t push_bundle, head;
  q_stat_t q_stat;

  // Front: classifies each word and decodes escapes into a bundle.
  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .q_stat      (q_stat),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // The queue absorbs multi-byte bursts so the front keeps taking words.
  jsu_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .q_stat      (q_stat)
  );

  // Back: one result per cycle when not stalled, run_last on a bundle's final one.
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

// ----- hdl/jsu_front.sv -----
// Decoder of the JSON string unescaper: accepts source bytes, tracks the
// literal's phase and turns each byte into one bundle of results. Uses jsu_pkg.
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_word_t in_data,
  output logic          in_stall,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output bundle_t       push_bundle
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp[20:7] == '0) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp[20:11] == '0) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  phase_t      phase_r, phase_nxt, ph_mid;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] hex_acc_r, hex_acc_nxt;
  logic        hex_bad_r, hex_bad_nxt;
  logic [9:0]  high_r, high_nxt;

  logic [7:0]  c;
  logic        last, accept, is_ws;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [15:0] acc_new;
  logic        bad_new, grp_done, is_high, is_low;
  logic [20:0] pair_cp;

  logic        do_fail, do_done, emit_raw, emit_cp, start_grp, take_dig, set_high;
  err_t        fail_code;
  logic [7:0]  raw_b;
  logic [20:0] cp;
  utf8_t       enc;

  assign c        = in_data.in_byte;
  assign last     = in_data.end_of_input;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);

  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      dig_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      dig_val = c[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign acc_new  = {hex_acc_r, dig_val};
  assign bad_new  = hex_bad_r || !dig_ok;
  assign grp_done = (hex_cnt_r == 2'd3);
  assign is_high  = (acc_new[15:10] == 6'b110110);
  assign is_low   = (acc_new[15:10] == 6'b110111);
  assign pair_cp  = 21'h10000 + {1'b0, high_r, acc_new[9:0]};

  // Main decode of one byte against the current phase.
  always_comb begin
    ph_mid    = phase_r;
    do_fail   = 1'b0;
    fail_code = ERR_NO_QUOTE;
    do_done   = 1'b0;
    emit_raw  = 1'b0;
    raw_b     = c;
    emit_cp   = 1'b0;
    cp        = {5'd0, acc_new};
    start_grp = 1'b0;
    take_dig  = 1'b0;
    set_high  = 1'b0;
    unique case (phase_r)
      PH_AWAIT: begin
        if (c == CH_QUOTE) begin
          ph_mid = PH_TEXT;
        end else if (!is_ws) begin
          do_fail = 1'b1;
        end
      end
      PH_TEXT: begin
        if (c == CH_QUOTE) begin
          do_done = 1'b1;
          ph_mid  = PH_AWAIT;
        end else if (c < 8'h20) begin
          do_fail   = 1'b1;
          fail_code = ERR_CONTROL;
        end else if (c == CH_BSLASH) begin
          ph_mid = PH_ESC;
        end else begin
          emit_raw = 1'b1;
        end
      end
      PH_ESC: begin
        ph_mid = PH_TEXT;
        if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
          emit_raw = 1'b1;
        end else if (c == 8'h62) begin
          emit_raw = 1'b1;
          raw_b    = CH_BS;
        end else if (c == 8'h66) begin
          emit_raw = 1'b1;
          raw_b    = CH_FF;
        end else if (c == 8'h6E) begin
          emit_raw = 1'b1;
          raw_b    = CH_LF;
        end else if (c == 8'h72) begin
          emit_raw = 1'b1;
          raw_b    = CH_CR;
        end else if (c == 8'h74) begin
          emit_raw = 1'b1;
          raw_b    = CH_TAB;
        end else if (c == 8'h75) begin
          start_grp = 1'b1;
          ph_mid    = PH_HEX;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_ESCAPE;
        end
      end
      PH_HEX: begin
        take_dig = 1'b1;
        if (grp_done) begin
          if (bad_new) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_HEX;
          end else if (is_high) begin
            set_high = 1'b1;
            ph_mid   = PH_BSL;
          end else if (is_low) begin
            do_fail   = 1'b1;
            fail_code = ERR_LONE_LOW;
          end else begin
            emit_cp = 1'b1;
            ph_mid  = PH_TEXT;
          end
        end
      end
      PH_BSL: begin
        if (c == CH_BSLASH && !last) begin
          ph_mid = PH_U;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_LONE_HIGH;
        end
      end
      PH_U: begin
        if (c == 8'h75 && !last) begin
          start_grp = 1'b1;
          ph_mid    = PH_LOW;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_LONE_HIGH;
        end
      end
      PH_LOW: begin
        take_dig = 1'b1;
        cp       = pair_cp;
        if (grp_done) begin
          if (bad_new) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_LOW_HEX;
          end else if (is_low) begin
            emit_cp = 1'b1;
            ph_mid  = PH_TEXT;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_LOW;
          end
        end
      end
      PH_HUNT: begin
        if (c == CH_QUOTE) begin
          ph_mid = PH_TEXT;
        end
      end
    endcase
    if (do_fail) begin
      ph_mid = PH_HUNT;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt   = last ? PH_AWAIT : ph_mid;
    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    hex_bad_nxt = hex_bad_r;
    high_nxt    = set_high ? acc_new[9:0] : high_r;
    if (start_grp) begin
      hex_cnt_nxt = 2'd0;
      hex_acc_nxt = '0;
      hex_bad_nxt = 1'b0;
    end else if (take_dig) begin
      hex_cnt_nxt = hex_cnt_r + 2'd1;
      hex_acc_nxt = acc_new[11:0];
      hex_bad_nxt = bad_new;
    end
  end

  // Bundle for the queue.
  always_comb begin
    enc         = utf8_encode(cp);
    push_bundle = '0;
    if (emit_raw) begin
      push_bundle.nbytes  = 3'd1;
      push_bundle.data[0] = raw_b;
    end else if (emit_cp) begin
      push_bundle.nbytes = enc.n;
      push_bundle.data   = enc.b;
    end
    push_bundle.term_kind = KIND_DONE;
    push_bundle.term_err  = ERR_NO_QUOTE;
    if (do_fail) begin
      push_bundle.has_term  = 1'b1;
      push_bundle.term_kind = KIND_ERROR;
      push_bundle.term_err  = fail_code;
    end else if (do_done) begin
      push_bundle.has_term = 1'b1;
    end else if (last) begin
      // The source ended with the literal still open, or with none opened.
      push_bundle.term_kind = KIND_ERROR;
      push_bundle.has_term  = 1'b1;
      unique case (ph_mid)
        PH_AWAIT: push_bundle.term_err = ERR_NO_QUOTE;
        PH_TEXT:  push_bundle.term_err = ERR_UNTERMINATED;
        PH_ESC:   push_bundle.term_err = ERR_OPEN_ESC;
        PH_HEX:   push_bundle.term_err = ERR_SHORT_U;
        PH_BSL, PH_U, PH_LOW: push_bundle.term_err = ERR_LONE_HIGH;
        PH_HUNT: begin
          push_bundle.has_term  = 1'b0;
          push_bundle.term_kind = KIND_DONE;
        end
      endcase
    end
    push = accept && ((push_bundle.nbytes != 3'd0) || push_bundle.has_term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_AWAIT;
      hex_cnt_r <= 2'd0;
      hex_acc_r <= '0;
      hex_bad_r <= 1'b0;
      high_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_acc_r <= hex_acc_nxt;
      hex_bad_r <= hex_bad_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/jsu_queue.sv -----
// Short queue of result bundles between decoder and serialiser.
// Uses jsu_pkg for the bundle type and depth.
`default_nettype none

module jsu_queue import jsu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_bundle,
  input  wire logic    pop,
  output bundle_t      head,
  output q_stat_t      q_stat
);

  bundle_t        q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign head         = q_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/jsu_back.sv -----
// Serialiser: walks the head bundle one result per cycle into the output
// register while not stalled and marks each bundle's final result. Uses jsu_pkg.
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bundle_t head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  output out_word_t    out_data,
  input  wire logic    out_stall
);

  logic       out_valid_r;
  out_word_t  out_r, out_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       is_last, load;

  assign total   = head.nbytes + {2'd0, head.has_term};
  assign is_last = (idx_r == total - 3'd1);
  assign load    = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop     = load && is_last;

  always_comb begin
    out_nxt          = '0;
    out_nxt.run_last = is_last;
    if (idx_r < head.nbytes) begin
      out_nxt.result_kind = KIND_DATA;
      out_nxt.out_byte    = head.data[idx_r[1:0]];
    end else begin
      out_nxt.result_kind = head.term_kind;
      out_nxt.error_code  = head.term_err;
    end
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for json_string_unescape: directed literals, back-pressure and
// random streams, with results predicted on the fly and compared word by word.
// Depends on jsu_pkg and the json_string_unescape RTL only.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  // Source characters that steer the decoder.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Data and completion words carry a zero error field.
  localparam err_t ERR_NONE = ERR_NO_QUOTE;

  // Cycles with no word moving on either channel before the run is abandoned. The
  // longest legal quiet stretch is the deliberate hold-off of the back-pressure test.
  localparam int IDLE_LIMIT = 1000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  in_word_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;
  logic      out_stall;

  json_string_unescape u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Unescaper state as the testbench sees it. It mirrors the decoder exactly:
  // the phase within a literal, the hex group being gathered and the high
  // surrogate waiting for its partner.
  // ---------------------------------------------------------------------------
  phase_t      u_phase     = PH_AWAIT;
  logic [2:0]  u_hex_count = 3'd0;
  logic [15:0] u_hex_acc   = 16'h0000;
  logic        u_hex_bad   = 1'b0;
  logic [15:0] u_high      = 16'h0000;
  logic        u_closed;

  out_word_t step_results[$];     // words caused by the byte being decoded
  out_word_t pending_results[$];  // words still owed by the block, oldest first

  int  fail_count   = 0;
  int  live_items   = 0;    // accepted bytes that were not merely dropped
  int  hold_request = 0;    // long receiver hold-off asked for by a test
  bit  src_idle_on  = 1'b1;
  bit  sink_idle_on = 1'b1;
  int  quiet_cycles = 0;

  function automatic void add_result(kind_t kind, logic [7:0] data, err_t code);
    out_word_t r;
    r.result_kind = kind;
    r.out_byte    = data;
    r.error_code  = code;
    r.run_last    = 1'b0;
    step_results.push_back(r);
  endfunction

  // An error ends the literal; everything up to the next quote is then dropped.
  function automatic void raise_error(err_t code);
    add_result(KIND_ERROR, 8'h00, code);
    u_phase  = PH_HUNT;
    u_closed = 1'b1;
  endfunction

  function automatic void add_utf8(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(KIND_DATA, cp[7:0], ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      add_result(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
      add_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      add_result(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
      add_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
      add_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
    end else begin
      add_result(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
      add_result(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
      add_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
      add_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
    end
  endfunction

  // Digits are only judged once all four are in, so a bad digit just marks the
  // group; its value then counts as zero.
  function automatic void gather_hex(logic [7:0] c);
    logic [3:0] nibble;
    nibble = 4'd0;
    if (c >= "0" && c <= "9") nibble = c[3:0];
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) nibble = c[3:0] + 4'd9;
    else u_hex_bad = 1'b1;
    u_hex_acc   = {u_hex_acc[11:0], nibble};
    u_hex_count = u_hex_count + 3'd1;
  endfunction

  function automatic void open_hex_group(phase_t next_phase);
    u_hex_count = 3'd0;
    u_hex_acc   = 16'h0000;
    u_hex_bad   = 1'b0;
    u_phase     = next_phase;
  endfunction

  // Decodes one accepted source byte and appends the words it must produce to
  // the store of words owed by the block.
  function automatic void unescape_byte(in_word_t w);
    logic [7:0] c;
    logic       last;
    logic       blank;
    out_word_t  r;
    c     = w.in_byte;
    last  = w.end_of_input;
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    step_results.delete();
    u_closed = 1'b0;
    case (u_phase)
      PH_AWAIT: begin
        if (c == CH_QUOTE) u_phase = PH_TEXT;
        else if (!blank) raise_error(ERR_NO_QUOTE);
      end
      PH_TEXT: begin
        if (c == CH_QUOTE) begin
          add_result(KIND_DONE, 8'h00, ERR_NONE);
          u_phase  = PH_AWAIT;
          u_closed = 1'b1;
        end else if (c < 8'h20) begin
          raise_error(ERR_CONTROL);
        end else if (c == CH_BSLASH) begin
          u_phase = PH_ESC;
        end else begin
          add_result(KIND_DATA, c, ERR_NONE);
        end
      end
      PH_ESC: begin
        u_phase = PH_TEXT;
        if (c == CH_QUOTE || c == CH_BSLASH || c == "/") add_result(KIND_DATA, c, ERR_NONE);
        else if (c == "b") add_result(KIND_DATA, 8'h08, ERR_NONE);
        else if (c == "f") add_result(KIND_DATA, 8'h0C, ERR_NONE);
        else if (c == "n") add_result(KIND_DATA, 8'h0A, ERR_NONE);
        else if (c == "r") add_result(KIND_DATA, 8'h0D, ERR_NONE);
        else if (c == "t") add_result(KIND_DATA, 8'h09, ERR_NONE);
        else if (c == "u") open_hex_group(PH_HEX);
        else raise_error(ERR_BAD_ESCAPE);
      end
      PH_HEX: begin
        gather_hex(c);
        if (u_hex_count >= 3'd4) begin
          if (u_hex_bad) begin
            raise_error(ERR_BAD_HEX);
          end else if (u_hex_acc >= 16'hD800 && u_hex_acc <= 16'hDBFF) begin
            u_high  = u_hex_acc;
            u_phase = PH_BSL;
          end else if (u_hex_acc >= 16'hDC00 && u_hex_acc <= 16'hDFFF) begin
            raise_error(ERR_LONE_LOW);
          end else begin
            add_utf8({5'd0, u_hex_acc});
            u_phase = PH_TEXT;
          end
        end
      end
      PH_BSL: begin
        if (c == CH_BSLASH && !last) u_phase = PH_U;
        else raise_error(ERR_LONE_HIGH);
      end
      PH_U: begin
        if (c == "u" && !last) open_hex_group(PH_LOW);
        else raise_error(ERR_LONE_HIGH);
      end
      PH_LOW: begin
        gather_hex(c);
        if (u_hex_count >= 3'd4) begin
          if (u_hex_bad) begin
            raise_error(ERR_BAD_LOW_HEX);
          end else if (u_hex_acc >= 16'hDC00 && u_hex_acc <= 16'hDFFF) begin
            add_utf8(21'h10000 + {1'b0, u_high[9:0], u_hex_acc[9:0]});
            u_phase = PH_TEXT;
          end else begin
            raise_error(ERR_BAD_LOW);
          end
        end
      end
      default: begin
        if (c == CH_QUOTE) u_phase = PH_TEXT;
      end
    endcase
    // The last byte of the source always leaves the decoder awaiting a quote;
    // a literal still open at that point is reported by where it stopped.
    if (last) begin
      if (!u_closed) begin
        case (u_phase)
          PH_AWAIT:            raise_error(ERR_NO_QUOTE);
          PH_TEXT:             raise_error(ERR_UNTERMINATED);
          PH_ESC:              raise_error(ERR_OPEN_ESC);
          PH_HEX:              raise_error(ERR_SHORT_U);
          PH_BSL, PH_U, PH_LOW: raise_error(ERR_LONE_HIGH);
          default: ;
        endcase
      end
      u_phase = PH_AWAIT;
    end
    foreach (step_results[i]) begin
      r          = step_results[i];
      r.run_last = (i == step_results.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking of result words.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: word %h arrived with nothing expected", $time, got);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
    compare_field("out_byte", want.out_byte, got.out_byte);
    compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
    compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
  endfunction

  // Receiving side. Words are sampled at the rising edge; out_stall moves at the
  // falling edge. After each word a fresh random hold is drawn while sink idling
  // is on, and a long hold asked for by a test is counted down here as well.
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_result(out_data);
        hold_left = sink_idle_on ? $urandom_range(0, 11) : 0;
      end
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending side. A byte is offered at a falling edge after a random gap and
  // held unchanged until the block takes it. Valid stays high when the next
  // byte follows with no gap, so back-to-back words are possible.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = {b, eoi};
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (u_phase != PH_HUNT) live_items++;
    unescape_byte(in_data);
  endtask

  task automatic send_text(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_last && (i == s.len() - 1));
  endtask

  // Stops offering and waits until every owed word has been received.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random bytes of a literal now and then carry end of input, so truncation
  // falls at every point of an escape.
  task automatic send_lit_byte(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 39) == 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return {4'h3, v};
    return {($urandom_range(0, 1) != 0) ? 4'h6 : 4'h4, 4'(v - 4'd9)};
  endfunction

  task automatic send_u_group(input logic [15:0] v);
    send_lit_byte(CH_BSLASH);
    send_lit_byte("u");
    for (int i = 3; i >= 0; i--) send_lit_byte(hex_char(v[4*i +: 4]));
  endtask

  // One literal of random content: mostly well-formed pieces, with some noise
  // bytes and broken escapes mixed in.
  task automatic send_random_literal();
    logic [7:0]  b;
    logic [15:0] v;
    int          bad_pos;
    string       blanks;
    string       esc;
    blanks = " \t\n\015";
    esc    = "\"\\/bfnrt";
    repeat ($urandom_range(0, 2)) send_lit_byte(blanks[$urandom_range(0, 3)]);
    if ($urandom_range(0, 9) == 0) send_lit_byte(8'($urandom()));
    send_lit_byte(CH_QUOTE);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
          send_lit_byte(b);
        end
        4, 5: begin
          send_lit_byte(CH_BSLASH);
          send_lit_byte(esc[$urandom_range(0, 7)]);
        end
        6: begin
          // Spread code points over the one, two and three byte encodings.
          case ($urandom_range(0, 2))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            default: begin
              v = 16'($urandom_range(16'h800, 16'hFFFF));
              if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
            end
          endcase
          send_u_group(v);
        end
        7: begin
          send_u_group(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
          send_u_group(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
        end
        8: send_lit_byte(8'($urandom()));
        default: begin
          case ($urandom_range(0, 4))
            0: begin
              bad_pos = $urandom_range(0, 3);
              send_lit_byte(CH_BSLASH);
              send_lit_byte("u");
              for (int i = 0; i < 4; i++) begin
                if (i == bad_pos) send_lit_byte(8'($urandom_range(8'h67, 8'h7A)));
                else send_lit_byte(hex_char(4'($urandom())));
              end
            end
            1: send_u_group(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
            2: begin
              send_u_group(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
              send_lit_byte(8'($urandom()));
            end
            3: begin
              send_u_group(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
              send_lit_byte(CH_BSLASH);
              send_lit_byte(8'($urandom()));
            end
            default: begin
              send_u_group(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
              send_u_group(16'($urandom()));
            end
          endcase
        end
      endcase
    end
    send_byte(CH_QUOTE, $urandom_range(0, 2) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Leading whitespace, plain bytes at both ends of the range, control bytes.
  task automatic test_whitespace_and_text();
    send_text(" \t\n\015\"A \177\377~\"", 1'b1);
    send_text("\"a\001\"\037", 1'b1);
  endtask

  // Garbage before the quote, recovery after an error and after a completion,
  // a source of nothing but whitespace, and end of input while hunting.
  task automatic test_garbage_and_recovery();
    send_text("x", 1'b0);
    send_text(" y\"ok\"", 1'b0);
    send_text("z", 1'b0);
    send_text("\"", 1'b1);
    send_text(" \t", 1'b1);
    send_text("qw", 1'b1);
  endtask

  task automatic test_simple_escapes();
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
    send_text("\"\\q\"", 1'b1);
  endtask

  // Boundaries between the UTF-8 lengths, the top of the basic plane, and the
  // lowest and highest pairs.
  task automatic test_unicode_escapes();
    send_text("\"\\u007F\\u0080\\u0800\\uFFFF", 1'b0);
    send_text("\\uD800\\uDC00\\udbff\\uDFFF\"", 1'b0);
  endtask

  // Errors in hex digits and surrogates; every error is followed by a quote
  // that opens the next literal.
  task automatic test_surrogate_errors();
    send_text("\"\\u12G4\"", 1'b0);
    send_text("\\uD800\\uDC0Z\"", 1'b0);
    send_text("\\uD800\\u0041\"", 1'b0);
    send_text("\\uDC00\"", 1'b0);
    send_text("\"", 1'b1);
  endtask

  // Truncation inside the text, after a backslash, inside a hex group and
  // inside a pair, and a four-byte sequence followed by its error, which is
  // the most one byte can cause.
  task automatic test_end_of_input();
    send_text("\"ab", 1'b1);
    send_text("\"a\\", 1'b1);
    send_text("\"\\u12", 1'b1);
    send_text("\"\\uD800\\u", 1'b1);
    send_text("\"\\uD83D\\uDE00", 1'b1);
  endtask

  // The receiver holds off while the sender keeps offering a four-byte
  // sequence and plain bytes, so the bundle queue fills and in_stall has to rise.
  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    hold_request = 150;
    send_text("\"\\uD83D\\uDE00abcd\"", 1'b0);
    src_idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_literals(input int n, input bit idle);
    int stop_at;
    src_idle_on  = idle;
    sink_idle_on = idle;
    stop_at      = live_items + n;
    while (live_items < stop_at) send_random_literal();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Unstructured bytes, quotes favoured so that literals keep being opened.
  task automatic test_noise(input int n);
    int         stop_at;
    logic [7:0] b;
    stop_at = live_items + n;
    while (live_items < stop_at) begin
      b = ($urandom_range(0, 3) == 0) ? CH_QUOTE : 8'($urandom());
      send_byte(b, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_whitespace_and_text();
    test_garbage_and_recovery();
    test_simple_escapes();
    test_unicode_escapes();
    test_surrogate_errors();
    test_end_of_input();
    drain_results();
    test_backpressure();
    test_random_literals(12, 1'b1);
    test_random_literals(6, 1'b0);
    test_noise(8);

    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
